/* rtl/srrr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrr_pkg
// Shared types and constants of the selective repeat reorder receiver.
// ----------------------------------------------------------------------------
package srrr_pkg;

  localparam int RING_DEPTH_DEF = 32;
  localparam int SEQ_W          = 32;
  localparam int HANDLE_W       = 32;
  localparam int BYTES_W        = 11;
  localparam int WIN_W          = 6;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 6;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd32;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SELECTIVE_ACK = 1'd1;

  localparam logic [1:0] PKT_DATA = 2'd0;
  localparam logic [1:0] PKT_END  = 2'd1;

  localparam logic [1:0] RES_ACK     = 2'd0;
  localparam logic [1:0] RES_DELIVER = 2'd1;
  localparam logic [1:0] RES_ERROR   = 2'd2;

  typedef enum logic [1:0] {
    CMD_ACK,
    CMD_ERROR,
    CMD_STORE,
    CMD_INORDER
  } cmd_op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_ACK,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]          packet_kind;
    logic [SEQ_W-1:0]    seq_number;
    logic                checksum_ok;
    logic [HANDLE_W-1:0] payload_handle;
    logic [BYTES_W-1:0]  payload_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [SEQ_W-1:0]    ack_or_seq;
    logic [HANDLE_W-1:0] out_handle;
    logic [BYTES_W-1:0]  out_bytes;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [SEQ_W-1:0]    num;
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  bytes;
    logic [WIN_W-1:0]    off;
    logic [WIN_W-1:0]    win;
    logic                sel;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  bytes;
  } slot_t;

  typedef struct packed {
    logic [SEQ_W-1:0] expected_seq;
    logic             run_done;
  } back_status_t;

endpackage

/* rtl/srrr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrr_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/srrr_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrr_cmd_fifo
// Two-entry command queue between the classifier and the execution side.
// ----------------------------------------------------------------------------
module srrr_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  srrr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output srrr_pkg::cmd_t head_cmd
);
  import srrr_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       entry [DEPTH];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full     = (count == 2'(DEPTH));
  assign empty    = (count == 2'd0);
  assign head_cmd = entry[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/srrr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrr_front
// Accepts packet descriptors, holds configuration, classifies each packet
// against the receive window and queues a command for the execution side.
// ----------------------------------------------------------------------------
module srrr_front #(
  parameter int RING_DEPTH = srrr_pkg::RING_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  srrr_pkg::in_item_t                  in_data,
  input  logic                                cfg_write,
  input  logic [srrr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [srrr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  srrr_pkg::back_status_t              status,
  output logic                                push,
  output srrr_pkg::cmd_t                      push_cmd,
  input  logic                                fifo_full
);
  import srrr_pkg::*;

  localparam logic [WIN_W-1:0] DEPTH_WIN = WIN_W'(RING_DEPTH);

  logic [WIN_W-1:0] win_cfg;
  logic             selective_ack;
  logic             session_closed;
  logic             inorder_pending;

  logic             accept;
  logic             push_ok;
  logic             close;
  cmd_op_t          op;
  logic [SEQ_W-1:0] num;
  logic [WIN_W-1:0] win_eff;
  logic [SEQ_W-1:0] win_ext;
  logic [SEQ_W-1:0] window_end;
  logic [SEQ_W-1:0] seq_off;
  logic [SEQ_W-1:0] old_limit;

  always_comb begin
    win_eff = win_cfg;
    if (win_cfg == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_cfg > DEPTH_WIN) begin
      win_eff = DEPTH_WIN;
    end
    win_ext    = {{(SEQ_W-WIN_W){1'b0}}, win_eff};
    window_end = status.expected_seq + win_ext;
    seq_off    = in_data.seq_number - status.expected_seq;
    old_limit  = in_data.seq_number + win_ext;
  end

  always_comb begin
    push_ok = 1'b0;
    close   = 1'b0;
    op      = CMD_ACK;
    num     = in_data.seq_number;
    if (!session_closed && in_data.checksum_ok) begin
      if (in_data.packet_kind == PKT_END) begin
        push_ok = 1'b1;
        close   = 1'b1;
      end else if (in_data.packet_kind == PKT_DATA &&
                   in_data.seq_number < window_end) begin
        if (in_data.seq_number > status.expected_seq) begin
          push_ok = 1'b1;
          op      = CMD_STORE;
          num     = selective_ack ? in_data.seq_number : status.expected_seq;
        end else if (in_data.seq_number == status.expected_seq) begin
          push_ok = 1'b1;
          op      = CMD_INORDER;
        end else if (selective_ack) begin
          push_ok = 1'b1;
          if (old_limit < status.expected_seq) begin
            op    = CMD_ERROR;
            close = 1'b1;
          end
        end
      end
    end
  end

  assign in_stall = inorder_pending || fifo_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && push_ok;

  always_comb begin
    push_cmd.op     = op;
    push_cmd.num    = num;
    push_cmd.handle = in_data.payload_handle;
    push_cmd.bytes  = in_data.payload_bytes;
    push_cmd.off    = seq_off[WIN_W-1:0];
    push_cmd.win    = win_eff;
    push_cmd.sel    = selective_ack;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg         <= WINDOW_RESET;
      selective_ack   <= 1'b0;
      session_closed  <= 1'b0;
      inorder_pending <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WINDOW_SIZE:   win_cfg       <= cfg_data[WIN_W-1:0];
          CFG_SELECTIVE_ACK: selective_ack <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept && close) begin
        session_closed <= 1'b1;
      end
      if (push && op == CMD_INORDER) begin
        inorder_pending <= 1'b1;
      end else if (status.run_done) begin
        inorder_pending <= 1'b0;
      end
    end
  end

endmodule

/* rtl/srrr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrr_back
// Executes queued commands: stores slots in the ring, scans the run of
// present slots after an in-order packet and emits acks, errors and deliveries.
// ----------------------------------------------------------------------------
module srrr_back #(
  parameter int RING_DEPTH = srrr_pkg::RING_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  srrr_pkg::cmd_t         cmd,
  output logic                   pop,
  output srrr_pkg::back_status_t status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output srrr_pkg::out_item_t    out_data
);
  import srrr_pkg::*;

  localparam int IW = $clog2(RING_DEPTH);
  localparam int RW = $clog2(RING_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(RING_DEPTH - 1);
  localparam logic [IW:0]   DEPTH_EXT = (IW+1)'(RING_DEPTH);

  back_state_t           state;
  back_state_t           state_next;
  logic [IW-1:0]         head;
  logic [SEQ_W-1:0]      expected_seq;
  logic [RING_DEPTH-1:0] present;
  logic [IW-1:0]         scan_idx;
  logic [RW-1:0]         run;
  logic [RW-1:0]         win_q;
  logic                  sel_q;
  logic [SEQ_W-1:0]      first_seq;
  logic [SEQ_W-1:0]      deliv_seq;
  logic [RW-1:0]         rem;
  logic [IW-1:0]         rd_ptr;
  logic [IW-1:0]         rd_ptr_next;
  logic                  run_done;

  logic                  out_free;
  logic                  out_load;
  out_item_t             out_next;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  slot_t                 ram_wdata;
  slot_t                 ram_rdata;
  logic                  clr_present;
  logic [IW:0]           store_sum;
  logic [IW-1:0]         store_pos;
  logic                  scan_more;
  logic [SEQ_W-1:0]      run_end_seq;

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] idx);
    inc_idx = (idx == LAST_IDX) ? '0 : idx + IW'(1);
  endfunction

  assign out_free    = !out_valid || !out_stall;
  assign store_sum   = {1'b0, head} + {1'b0, cmd.off[IW-1:0]};
  assign store_pos   = (store_sum >= DEPTH_EXT) ? IW'(store_sum - DEPTH_EXT)
                                                : store_sum[IW-1:0];
  assign scan_more   = (run < win_q) && present[scan_idx];
  assign run_end_seq = first_seq + {{(SEQ_W-RW){1'b0}}, run};

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (cmd_valid && out_free && cmd.op == CMD_INORDER) begin
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if (!scan_more) begin
          state_next = B_ACK;
        end
      end
      B_ACK: begin
        if (out_free) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free && rem == RW'(1)) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = head;
    ram_wdata   = '{handle: cmd.handle, bytes: cmd.bytes};
    out_load    = 1'b0;
    out_next    = '0;
    rd_ptr_next = rd_ptr;
    clr_present = 1'b0;
    case (state)
      B_IDLE: begin
        rd_ptr_next = head;
        if (cmd_valid && out_free) begin
          pop = 1'b1;
          case (cmd.op)
            CMD_ACK: begin
              out_load             = 1'b1;
              out_next.result_kind = RES_ACK;
              out_next.ack_or_seq  = cmd.num;
              out_next.last_of_run = 1'b1;
            end
            CMD_ERROR: begin
              out_load             = 1'b1;
              out_next.result_kind = RES_ERROR;
              out_next.ack_or_seq  = cmd.num;
              out_next.last_of_run = 1'b1;
            end
            CMD_STORE: begin
              ram_we               = 1'b1;
              ram_waddr            = store_pos;
              out_load             = 1'b1;
              out_next.result_kind = RES_ACK;
              out_next.ack_or_seq  = cmd.num;
              out_next.last_of_run = 1'b1;
            end
            CMD_INORDER: begin
              ram_we = 1'b1;
            end
            default: ;
          endcase
        end
      end
      B_ACK: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next.result_kind = RES_ACK;
          out_next.ack_or_seq  = sel_q ? first_seq : run_end_seq;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next.result_kind = RES_DELIVER;
          out_next.ack_or_seq  = deliv_seq;
          out_next.out_handle  = ram_rdata.handle;
          out_next.out_bytes   = ram_rdata.bytes;
          out_next.last_of_run = (rem == RW'(1));
          clr_present          = 1'b1;
          rd_ptr_next          = inc_idx(rd_ptr);
        end
      end
      default: ;
    endcase
  end

  srrr_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (RING_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      head         <= '0;
      expected_seq <= '0;
      present      <= '0;
      run_done     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state    <= state_next;
      run_done <= 1'b0;
      if (ram_we) begin
        present[ram_waddr] <= 1'b1;
      end
      if (clr_present) begin
        present[rd_ptr] <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == B_EMIT && out_free && rem == RW'(1)) begin
        head         <= inc_idx(rd_ptr);
        expected_seq <= run_end_seq;
        run_done     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
    if (out_load) begin
      out_data <= out_next;
    end
    case (state)
      B_IDLE: begin
        scan_idx  <= inc_idx(head);
        run       <= RW'(1);
        win_q     <= cmd.win[RW-1:0];
        sel_q     <= cmd.sel;
        first_seq <= cmd.num;
      end
      B_SCAN: begin
        if (scan_more) begin
          run      <= run + RW'(1);
          scan_idx <= inc_idx(scan_idx);
        end
      end
      B_ACK: begin
        rem       <= run;
        deliv_seq <= first_seq;
      end
      B_EMIT: begin
        if (out_free) begin
          rem       <= rem - RW'(1);
          deliv_seq <= deliv_seq + SEQ_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign status.expected_seq = expected_seq;
  assign status.run_done     = run_done;

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN) |-> (run >= RW'(1) && run <= win_q))
    else $error("run length outside the window during scan");

  a_head_present: assert property (@(posedge clk) disable iff (rst)
    (state == B_SCAN) |-> present[head])
    else $error("in-order slot not marked present during scan");

  a_emit_present: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT) |-> present[rd_ptr])
    else $error("delivering a slot that is not present");

  a_run_close: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT && out_free && rem == RW'(1)) |=> (run_done && state == B_IDLE))
    else $error("final delivery did not close the run");
`endif

endmodule

/* rtl/selective_repeat_reorder_receiver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_reorder_receiver_core
// Receive window of a selective repeat transport: stores out-of-order data
// packets in a ring and releases in-order runs as deliveries.
// ----------------------------------------------------------------------------
// A packet descriptor that is dropped goes no further than the classifier;
// one that only causes an ack or an error passes the two-entry command queue
// and is answered by the execution side once it reaches the queue head. An
// in-order packet that releases a run of N slots is stored, its slot presence
// bits are walked one per cycle, its ack is issued and then N deliveries, one
// slot RAM read per cycle while the output is not stalled. The input stalls
// from its acceptance until the registered run-done flag of the last delivery
// clears the pending in-order flag; the new expected number arrives with
// that flag. Presence bits clear at reset, so there is no clearing pass.
// Configuration is taken on any cycle with cfg_write high.
// ----------------------------------------------------------------------------
module selective_repeat_reorder_receiver_core #(
  parameter int RING_DEPTH = srrr_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  srrr_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output srrr_pkg::out_item_t              out_data,
  input  logic                             cfg_write,
  input  logic [srrr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srrr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import srrr_pkg::*;

  back_status_t status;
  logic         push;
  cmd_t         push_cmd;
  logic         fifo_full;
  logic         fifo_empty;
  logic         pop;
  cmd_t         head_cmd;

  srrr_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full)
  );

  srrr_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .empty    (fifo_empty),
    .head_cmd (head_cmd)
  );

  srrr_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!fifo_empty),
    .cmd       (head_cmd),
    .pop       (pop),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
